// ===== src/sacl_pkg.sv =====
// Shared types, constants and helpers for the set-associative cache LRU tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
package sacl_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int WAYS         = 8;
    localparam int ADDR_WIDTH   = 64;

    localparam int NSETS   = 1 << MAX_SET_BITS;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int ECNT_W  = $clog2(WAYS + 1);
    localparam int CNT_W   = 32;
    localparam int TSH_W   = 7;

    localparam int SETB_W  = 4;
    localparam int BLKB_W  = 6;
    localparam int WAYSR_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STORE  = 2'd1,
        FUNC_MODIFY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SECOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval;
        logic second;
        logic last_out;
    } sacl_cmd_t;

    // One set as stored in the row memory.
    typedef struct packed {
        logic [WAYS-1:0][ADDR_WIDTH-1:0] tag;
        logic [WAYS-1:0]                 valid;
        logic [WAYS-1:0][RANK_W-1:0]     rank;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ===== src/set_assoc_cache_lru_tracker_top.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    func, addr
// out       out_valid / out_ready  outcome, hit_total, miss_total, evict_total, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load or store reads its set row from the row RAM on the accepting edge; in the evaluate
// state the row is compared, updated and written back, and the result enters the output
// register. A modify then passes through a second-result state for its second result.
// No new access is taken until the last result of the previous one is loaded. Reset is
// immediate; the row RAM needs no clearing pass. A stalled output
// holds the controller in its evaluate or second-result state until the register frees.
//
// Top level of the set-associative cache LRU tracker.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
module set_assoc_cache_lru_tracker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [sacl_pkg::ADDR_WIDTH-1:0]    addr,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         outcome,
    output logic [sacl_pkg::CNT_W-1:0]         hit_total,
    output logic [sacl_pkg::CNT_W-1:0]         miss_total,
    output logic [sacl_pkg::CNT_W-1:0]         evict_total,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sacl_pkg::*;

    sacl_cmd_t cmd;

    sacl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sacl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (addr),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outcome     (outcome),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total),
        .last        (last)
    );

    // A new access is never taken while a lookup is being resolved.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(cmd.eval || cmd.second))
        else $error("access accepted during a lookup");

    // While the first result of a modify waits, no new access may enter.
    a_first_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("access accepted before second modify result");

    // Hit count moves only by one step.
    a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hit_total) |-> (hit_total == $past(hit_total) + 32'd1))
        else $error("hit count jumped");

    // Evictions are only counted by a set evaluation.
    a_evict_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(evict_total) |-> $past(cmd.eval))
        else $error("eviction counted outside evaluation");

endmodule

// ===== src/sacl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sacl_ctrl.sv =====
// Controller state machine for the cache LRU tracker: handshakes and sequencing.
// Depends on sacl_pkg for the state, function and command types.
module sacl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sacl_pkg::sacl_cmd_t  cmd
);
    import sacl_pkg::*;

    state_t state_reg, state_next;
    logic   modify_reg, modify_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   load;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        modify_next    = modify_reg;
        load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func_t'(func)) inside
                        FUNC_LOAD, FUNC_STORE:
                        begin
                            state_next  = ST_LOOK;
                            modify_next = 1'b0;
                        end
                        FUNC_MODIFY:
                        begin
                            state_next  = ST_LOOK;
                            modify_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = modify_reg ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.eval     = (state_reg == ST_LOOK) && out_free;
        cmd.second   = (state_reg == ST_SECOND) && out_free;
        cmd.last_out = ((state_reg == ST_LOOK) && !modify_reg) || (state_reg == ST_SECOND);
        out_valid    = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modify_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modify_reg    <= modify_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/sacl_dp.sv =====
// Datapath for the cache LRU tracker: configuration, set row memory, tag
// compare, LRU update and counters. Depends on sacl_pkg and sacl_ram.
module sacl_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sacl_pkg::sacl_cmd_t                   cmd,
    input  logic [sacl_pkg::ADDR_WIDTH-1:0]       addr,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [1:0]                            outcome,
    output logic [sacl_pkg::CNT_W-1:0]            hit_total,
    output logic [sacl_pkg::CNT_W-1:0]            miss_total,
    output logic [sacl_pkg::CNT_W-1:0]            evict_total,
    output logic                                  last
);
    import sacl_pkg::*;

    // Configuration
    logic [SETB_W-1:0]  set_bits_reg;
    logic [BLKB_W-1:0]  block_bits_reg;
    logic [WAYSR_W-1:0] ways_reg;
    logic [SETB_W-1:0]  sb_eff;
    logic [ECNT_W-1:0]  ways_eff;

    // Address split
    logic [ADDR_WIDTH-1:0] shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;
    logic [TSH_W-1:0]      tag_shift;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;

    // Row memory and per-set initialized flags
    logic [NSETS-1:0]      row_init_reg;
    logic [ROW_W-1:0]      row_rdata;
    row_t                  row_q;
    row_t                  row_eff;
    row_t                  row_new;

    // Lookup
    logic                  hit_found;
    logic [WAY_W-1:0]      hit_way;
    logic                  inv_found;
    logic [WAY_W-1:0]      inv_way;
    logic [WAY_W-1:0]      victim;
    logic [WAY_W-1:0]      sel_way;
    logic [RANK_W:0]       older;
    outcome_t              res;

    // Counters and result payload
    logic [CNT_W-1:0]      hits_reg, hits_next;
    logic [CNT_W-1:0]      misses_reg, misses_next;
    logic [CNT_W-1:0]      evicts_reg, evicts_next;
    outcome_t              outcome_reg;
    logic                  last_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sb_eff = (set_bits_reg > SETB_W'(MAX_SET_BITS)) ? SETB_W'(MAX_SET_BITS) : set_bits_reg;
        if (ways_reg == '0)
        begin
            ways_eff = ECNT_W'(1);
        end
        else if ({1'b0, ways_reg} > (WAYSR_W + 1)'(WAYS))
        begin
            ways_eff = ECNT_W'(WAYS);
        end
        else
        begin
            ways_eff = ECNT_W'(ways_reg);
        end
    end

    // A shift of the whole width or more leaves zero, as required for the tag.
    always_comb
    begin
        shifted   = addr >> block_bits_reg;
        set_mask  = ~({SET_W{1'b1}} << sb_eff);
        set_in    = shifted[SET_W-1:0] & set_mask;
        tag_shift = TSH_W'(sb_eff) + TSH_W'(block_bits_reg);
        tag_in    = addr >> tag_shift;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_rows (
        .clk   (clk),
        .we    (cmd.eval),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (cmd.accept),
        .raddr (set_in),
        .rdata (row_rdata)
    );

    // A set never written since reset reads as empty with all ranks zero.
    always_comb
    begin
        row_q   = row_t'(row_rdata);
        row_eff = row_q;
        if (!row_init_reg[set_reg])
        begin
            row_eff.valid = '0;
            row_eff.rank  = '0;
        end
    end

    always_comb
    begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        // Scan downward so the lowest matching way wins.
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if ((i < int'(ways_eff)) && row_eff.valid[i] && (row_eff.tag[i] == tag_reg))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if ((i < int'(ways_eff)) && !row_eff.valid[i])
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(i);
            end
        end
        victim = '0;
        for (int i = 1; i < WAYS; i++)
        begin
            if ((i < int'(ways_eff)) && (row_eff.rank[i] > row_eff.rank[victim]))
            begin
                victim = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        if (hit_found)
        begin
            sel_way = hit_way;
            older   = {1'b0, row_eff.rank[hit_way]};
            res     = OUT_HIT;
        end
        else if (inv_found)
        begin
            sel_way = inv_way;
            older   = (RANK_W + 1)'(WAYS);
            res     = OUT_MISS;
        end
        else
        begin
            sel_way = victim;
            older   = {1'b0, row_eff.rank[victim]};
            res     = OUT_EVICT;
        end

        row_new = row_eff;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == sel_way)
            begin
                row_new.rank[i] = '0;
            end
            else if (row_eff.valid[i] && ({1'b0, row_eff.rank[i]} < older) &&
                     (row_eff.rank[i] < RANK_W'(WAYS - 1)))
            begin
                row_new.rank[i] = row_eff.rank[i] + 1'b1;
            end
        end
        if (!hit_found)
        begin
            row_new.valid[sel_way] = 1'b1;
            row_new.tag[sel_way]   = tag_reg;
        end
    end

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        if (cmd.second)
        begin
            hits_next = sat_inc(hits_reg);
        end
        else if (cmd.eval)
        begin
            if (res == OUT_HIT)
            begin
                hits_next = sat_inc(hits_reg);
            end
            else
            begin
                misses_next = sat_inc(misses_reg);
            end
            if (res == OUT_EVICT)
            begin
                evicts_next = sat_inc(evicts_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= BLKB_W'(4);
            ways_reg       <= WAYSR_W'(1);
            row_init_reg   <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[SETB_W-1:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLKB_W-1:0];
                    CFG_WAYS:       ways_reg       <= cfg_data[WAYSR_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.eval)
            begin
                row_init_reg[set_reg] <= 1'b1;
            end
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            outcome_reg <= res;
            last_reg    <= cmd.last_out;
        end
        else if (cmd.second)
        begin
            outcome_reg <= OUT_HIT;
            last_reg    <= cmd.last_out;
        end
    end

    // The counters only move when a new result is loaded, so they double as
    // the output payload.
    assign outcome     = outcome_reg;
    assign last        = last_reg;
    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign evict_total = evicts_reg;

endmodule
